// ===== src/ctp_pkg.sv =====
// shared constants, types and the sine table builder for the carrier tracking pll
package ctp_pkg;

	localparam int TABLE_ADDR_BITS = 10;
	localparam int CORDIC_STEPS = 16;
	localparam int TBL_SIZE = 1 << TABLE_ADDR_BITS;
	localparam int MAX_STEPS = 24;
	localparam int ITER_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam longint GEN_GAIN = 64'sd652032874;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_SMOOTHING = 2'd0,
		REG_CENTER    = 2'd1,
		REG_LOW       = 2'd2,
		REG_HIGH      = 2'd3
	} cfg_index_t;

	// reset values of the configuration registers
	localparam logic [15:0] BETA_RESET = 16'd65000;
	localparam logic signed [15:0] CENTER_RESET = 16'sd6485;
	localparam logic signed [15:0] LOW_RESET = 16'sd6300;
	localparam logic signed [15:0] HIGH_RESET = 16'sd6670;

	// arctangent of 2^-i in turns, 2^32 per turn
	typedef logic [31:0] atan_tab_t [MAX_STEPS];
	localparam atan_tab_t ATAN_TURNS = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
	};

	typedef logic [14:0] sine_rom_t [TBL_SIZE];

	// quarter-wave sine table, built by rotation cordic at elaboration
	function automatic sine_rom_t build_table();
		sine_rom_t t;
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		longint s;
		for (int k = 0; k < TBL_SIZE; k++) begin
			x = GEN_GAIN;
			y = 0;
			z = longint'(k) * (longint'(1) << (30 - TABLE_ADDR_BITS));
			for (int i = 0; i < MAX_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - longint'(ATAN_TURNS[i]);
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + longint'(ATAN_TURNS[i]);
				end
			end
			s = (y * 32767 + (longint'(1) << 29)) >>> 30;
			if (s < 0) s = 0;
			if (s > 32767) s = 32767;
			t[k] = s[14:0];
		end
		return t;
	endfunction

	// commands from controller to datapath
	typedef struct packed {
		logic              load_in;
		logic              rom_rd;
		logic              rom_cos;
		logic              cap_s;
		logic              cap_c;
		logic              mul_re;
		logic              mul_im;
		logic              cord_init;
		logic              cord_step;
		logic              filt_mul;
		logic              filt_upd;
		logic              out_load;
		logic [ITER_W-1:0] iter;
	} ctp_cmd_t;

endpackage

// ===== src/ctp_datapath.sv =====
// datapath: config registers, sine rom, mixer, cordic atan2, loop filter and nco
module ctp_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic [31:0]       in_data,
	input  ctp_pkg::ctp_cmd_t cmd,
	output logic [47:0]       out_data
);

	localparam ctp_pkg::sine_rom_t ROM = ctp_pkg::build_table();
	localparam int AW = ctp_pkg::TABLE_ADDR_BITS;
	localparam int CW = 36;

	logic [15:0] beta_q;
	logic signed [15:0] center_q, low_q, high_q;
	logic signed [15:0] step_q;
	logic [15:0] phase_q;
	logic signed [15:0] si_q, sq_q, s_q, c_q;
	logic [14:0] rom_q;
	logic rom_special_q, rom_neg_q;
	logic signed [31:0] mul_a_q, mul_b_q;
	logic signed [32:0] re_q;
	logic signed [CW-1:0] x_q, y_q;
	logic [31:0] z_q;
	logic zero_q;
	logic signed [16:0] err_q;
	logic signed [34:0] prod_q;
	logic [47:0] out_q;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q <= ctp_pkg::BETA_RESET;
			center_q <= ctp_pkg::CENTER_RESET;
			low_q <= ctp_pkg::LOW_RESET;
			high_q <= ctp_pkg::HIGH_RESET;
		end else if (cfg_we) begin
			case (ctp_pkg::cfg_index_t'(cfg_index))
				ctp_pkg::REG_SMOOTHING: beta_q <= cfg_data;
				ctp_pkg::REG_CENTER:    center_q <= cfg_data;
				ctp_pkg::REG_LOW:       low_q <= cfg_data;
				ctp_pkg::REG_HIGH:      high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// rom address from the phase (sine or cosine)
	logic [15:0] rd_phase;
	logic [1:0] quad;
	logic [AW-1:0] idx;
	logic [AW-1:0] rom_addr;
	assign rd_phase = cmd.rom_cos ? phase_q + 16'h4000 : phase_q;
	assign quad = rd_phase[15:14];
	assign idx = AW'(rd_phase[13:0] >> (14 - AW));
	assign rom_addr = quad[0] ? AW'(AW'(0) - idx) : idx;

	always_ff @(posedge clk) begin
		if (cmd.rom_rd) begin
			rom_q <= ROM[rom_addr];
			rom_special_q <= quad[0] && (idx == '0);
			rom_neg_q <= quad[1];
		end
	end

	// table value with special case at a quarter turn and sign by quadrant
	logic signed [15:0] mag, trig;
	assign mag = rom_special_q ? 16'sd32767 : signed'({1'b0, rom_q});
	assign trig = rom_neg_q ? -mag : mag;

	// cordic step terms
	logic signed [CW-1:0] dx, dy;
	logic signed [32:0] im_w;
	logic signed [32:0] re_abs, im_adj;
	assign dx = y_q >>> cmd.iter;
	assign dy = x_q >>> cmd.iter;
	assign im_w = 33'(mul_a_q) + 33'(mul_b_q);
	assign re_abs = re_q[32] ? -re_q : re_q;
	assign im_adj = re_q[32] ? -im_w : im_w;

	// angle rounded to 16-bit turns, error and filter
	logic [31:0] z_rnd;
	logic signed [15:0] ang;
	logic signed [16:0] err_w;
	logic signed [34:0] prod_r;
	logic signed [19:0] next_w;
	logic out_of_range;
	assign z_rnd = z_q + 32'h8000;
	assign ang = signed'(z_rnd[31:16]);
	assign err_w = zero_q ? 17'sd0 : -17'(ang);
	assign prod_r = prod_q + 35'sd32768;
	assign next_w = 20'(err_q) + 20'(prod_r >>> 16);
	assign out_of_range = (next_w < 20'(low_q)) || (next_w > 20'(high_q));

	// nco state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ctp_pkg::CENTER_RESET;
			phase_q <= '0;
		end else if (cmd.filt_upd) begin
			step_q <= out_of_range ? center_q : next_w[15:0];
			phase_q <= phase_q + (out_of_range ? center_q : next_w[15:0]);
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			si_q <= signed'(in_data[15:0]);
			sq_q <= signed'(in_data[31:16]);
		end
		if (cmd.cap_s) s_q <= trig;
		if (cmd.cap_c) c_q <= trig;
		if (cmd.mul_re) begin
			mul_a_q <= c_q * si_q;
			mul_b_q <= s_q * sq_q;
		end
		if (cmd.mul_im) begin
			re_q <= 33'(mul_a_q) - 33'(mul_b_q);
			mul_a_q <= c_q * sq_q;
			mul_b_q <= s_q * si_q;
		end
		if (cmd.cord_init) begin
			zero_q <= (re_q == '0) && (im_w == '0);
			x_q <= CW'(re_abs);
			y_q <= CW'(im_adj);
			z_q <= re_q[32] ? 32'h8000_0000 : 32'h0;
		end
		if (cmd.cord_step) begin
			if (y_q > 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ctp_pkg::ATAN_TURNS[cmd.iter];
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ctp_pkg::ATAN_TURNS[cmd.iter];
			end
		end
		if (cmd.filt_mul) begin
			err_q <= err_w;
			prod_q <= signed'({1'b0, beta_q}) * (18'(step_q) - 18'(err_w));
		end
		if (cmd.out_load) out_q <= {phase_q, step_q, s_q};
	end

	assign out_data = out_q;

endmodule

// ===== src/ctp_control.sv =====
// controller: sequences one sample through the datapath and owns the handshakes
module ctp_control (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output ctp_pkg::ctp_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_SIN, S_COS, S_CAPC, S_MUL1, S_MUL2, S_INIT, S_CORD,
		S_FILT1, S_FILT2, S_OUT
	} state_t;

	state_t state_q;
	logic [ctp_pkg::ITER_W-1:0] iter_q;
	logic m_tvalid_q;
	logic out_free;
	logic last_iter;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign last_iter = (iter_q == ctp_pkg::ITER_W'(ctp_pkg::CORDIC_STEPS - 1));

	// commands decoded from the state
	always_comb begin
		cmd = '0;
		cmd.iter = iter_q;
		cmd.load_in = s_tvalid && (state_q == S_IDLE);
		cmd.rom_rd = (state_q == S_SIN) || (state_q == S_COS);
		cmd.rom_cos = (state_q == S_COS);
		cmd.cap_s = (state_q == S_COS);
		cmd.cap_c = (state_q == S_CAPC);
		cmd.mul_re = (state_q == S_MUL1);
		cmd.mul_im = (state_q == S_MUL2);
		cmd.cord_init = (state_q == S_INIT);
		cmd.cord_step = (state_q == S_CORD);
		cmd.filt_mul = (state_q == S_FILT1);
		cmd.filt_upd = (state_q == S_FILT2);
		cmd.out_load = (state_q == S_OUT) && out_free;
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				S_IDLE:  if (s_tvalid) state_q <= S_SIN;
				S_SIN:   state_q <= S_COS;
				S_COS:   state_q <= S_CAPC;
				S_CAPC:  state_q <= S_MUL1;
				S_MUL1:  state_q <= S_MUL2;
				S_MUL2:  state_q <= S_INIT;
				S_INIT: begin
					iter_q <= '0;
					state_q <= S_CORD;
				end
				S_CORD: begin
					iter_q <= iter_q + 1'b1;
					if (last_iter) state_q <= S_FILT1;
				end
				S_FILT1: state_q <= S_FILT2;
				S_FILT2: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a result never overwrites one that is still waiting
	a_out_safe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid_q || m_tready))
		else $error("result loaded over a pending result");

	// an accepted request starts the table reads
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_SIN))
		else $error("accepted request did not start");

	// cordic leaves after its last iteration
	a_cord_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CORD && last_iter) |=> (state_q == S_FILT1))
		else $error("cordic did not finish");

endmodule

// ===== src/carrier_tracking_pll.sv =====
// top level of the carrier tracking pll: controller plus datapath
// Each request runs table reads, mixer, iterative cordic (longest step), loop filter and
// output load; the next request is taken after that load, which waits on a pending result.
// A finished result waits in the output register while the next request is taken.
// Reset (arst_n low, asynchronous): config registers to their defaults, phase to zero,
// phase step to the default center increment, no result pending.
module carrier_tracking_pll (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // sample_i [15:0], sample_q [31:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // nco_sine [15:0], freq_word [31:16], phase_word [47:32]
);

	ctp_pkg::ctp_cmd_t cmd;

	ctp_control u_control (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	ctp_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.out_data  (m_tdata)
	);

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the carrier tracking pll: stimulus, predictor and scoreboard
module tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = 2'd0;
	logic [15:0] cfg_data = 16'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = 32'd0;  // sample_i [15:0], sample_q [31:16]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;          // nco_sine [15:0], freq_word [31:16], phase_word [47:32]

	localparam int LATENCY = 9 + ctp_pkg::CORDIC_STEPS;
	localparam longint CYCLE_LIMIT = 64'd2000000;

	// phase in the top bits, sine in the low bits, as on m_tdata
	typedef struct packed {
		logic [15:0]        phase;
		logic signed [15:0] freq;
		logic signed [15:0] sine;
	} pll_out_t;

	typedef struct {
		logic signed [15:0] i_val;
		logic signed [15:0] q_val;
		bit                 has_gold;
		pll_out_t           gold;
	} stim_row_t;

	carrier_tracking_pll u_dut (.*);

	always #1 clk = ~clk;

	// predictor state and its copy of the registers
	logic [15:0]        beta_q;
	logic signed [15:0] center_q, low_q, high_q;
	logic [15:0]        phase_q;
	logic signed [15:0] step_q;
	int                 quarter_sine [ctp_pkg::TBL_SIZE];

	pll_out_t expected_q[$];
	int       fail_cnt = 0;
	longint   cyc = 0;
	bit       hold_off = 1'b0;
	int       rx_done = 0;

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	// rotation cordic builds the quarter-wave table
	task automatic fill_quarter_sine();
		longint x, y, z, dx, dy, s;
		for (int k = 0; k < ctp_pkg::TBL_SIZE; k++) begin
			x = ctp_pkg::GEN_GAIN;
			y = 0;
			z = longint'(k) * (longint'(1) << (30 - ctp_pkg::TABLE_ADDR_BITS));
			for (int i = 0; i < ctp_pkg::MAX_STEPS; i++) begin
				dx = floor_shift(y, i);
				dy = floor_shift(x, i);
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(ctp_pkg::ATAN_TURNS[i]);
				end else begin
					x += dx; y -= dy; z += longint'(ctp_pkg::ATAN_TURNS[i]);
				end
			end
			s = floor_shift(y * 32767 + (longint'(1) << 29), 30);
			if (s < 0) s = 0;
			if (s > 32767) s = 32767;
			quarter_sine[k] = int'(s);
		end
	endtask

	function automatic longint nco_sine_of(logic [15:0] p);
		logic [1:0] quad;
		int         idx;
		longint     v;
		quad = p[15:14];
		idx = int'(p[13:0]) >> (14 - ctp_pkg::TABLE_ADDR_BITS);
		if (quad[0])
			v = (idx == 0) ? 32767 :
				quarter_sine[(ctp_pkg::TBL_SIZE - idx) & (ctp_pkg::TBL_SIZE - 1)];
		else
			v = quarter_sine[idx & (ctp_pkg::TBL_SIZE - 1)];
		return quad[1] ? -v : v;
	endfunction

	// vectoring cordic, angle in 16-bit turns wrapped signed
	function automatic longint angle_turns(longint x, longint y);
		logic [31:0] z;
		logic [31:0] r;
		longint      dx, dy;
		z = 32'd0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			x = -x; y = -y; z = 32'h8000_0000;
		end
		for (int i = 0; i < ctp_pkg::CORDIC_STEPS; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (y > 0) begin
				x += dx; y -= dy; z += ctp_pkg::ATAN_TURNS[i];
			end else begin
				x -= dx; y += dy; z -= ctp_pkg::ATAN_TURNS[i];
			end
		end
		r = (z + 32'h8000) >> 16;
		return longint'($signed(r[15:0]));
	endfunction

	function automatic pll_out_t track_sample(logic signed [15:0] si, logic signed [15:0] sq);
		longint   c, s, re, im, err, nxt;
		pll_out_t o;
		c = nco_sine_of(phase_q + 16'h4000);
		s = nco_sine_of(phase_q);
		re = c * si - s * sq;
		im = c * sq + s * si;
		err = -angle_turns(re, im);
		nxt = err + floor_shift(longint'(beta_q) * (longint'(step_q) - err) + 32768, 16);
		if (nxt < longint'(low_q) || nxt > longint'(high_q)) nxt = center_q;
		step_q = nxt[15:0];
		phase_q = phase_q + step_q;
		o.sine = s[15:0];
		o.freq = step_q;
		o.phase = phase_q;
		return o;
	endfunction

	task automatic predictor_reset();
		beta_q = ctp_pkg::BETA_RESET;
		center_q = ctp_pkg::CENTER_RESET;
		low_q = ctp_pkg::LOW_RESET;
		high_q = ctp_pkg::HIGH_RESET;
		phase_q = 16'd0;
		step_q = ctp_pkg::CENTER_RESET;
	endtask

	// register write, block idle
	task automatic write_reg(ctp_pkg::cfg_index_t idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ctp_pkg::REG_SMOOTHING: beta_q = val;
			ctp_pkg::REG_CENTER:    center_q = val;
			ctp_pkg::REG_LOW:       low_q = val;
			ctp_pkg::REG_HIGH:      high_q = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic send_request(logic signed [15:0] si, logic signed [15:0] sq,
		bit has_gold, pll_out_t gold, bit gaps);
		pll_out_t p;
		int       gap;
		gap = gaps ? $urandom_range(0, 19) : 0;
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {sq, si};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		p = track_sample(si, sq);
		if (has_gold && p != gold) begin
			$error("directed row prediction %h differs from typed value %h", p, gold);
			fail_cnt++;
		end
		expected_q.push_back(has_gold ? gold : p);
	endtask

	// result checking
	always @(posedge clk) begin
		pll_out_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			rx_done++;
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: %h", m_tdata);
				fail_cnt++;
			end else begin
				want = expected_q.pop_front();
				if (got.sine !== want.sine) begin
					$error("nco_sine expected %0d got %0d", want.sine, got.sine);
					fail_cnt++;
				end
				if (got.freq !== want.freq) begin
					$error("freq_word expected %0d got %0d", want.freq, got.freq);
					fail_cnt++;
				end
				if (got.phase !== want.phase) begin
					$error("phase_word expected %0d got %0d", want.phase, got.phase);
					fail_cnt++;
				end
			end
		end
	end

	// receiver stalls, with a long hold-off on request
	always @(posedge clk) begin
		int wait_left;
		if (hold_off) m_tready <= 1'b0;
		else if (wait_left > 0) begin
			wait_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (m_tvalid && m_tready)
				wait_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cyc++;
		if (cyc > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	stim_row_t directed [] = '{
		'{16'sd0, 16'sd0, 1'b1, '{sine: 16'sd0, freq: 16'sd6432, phase: 16'd6432}},
		'{16'sd32767, 16'sd0, 1'b0, '0},
		'{-16'sd32768, 16'sd0, 1'b0, '0},
		'{16'sd0, 16'sd32767, 1'b0, '0},
		'{16'sd0, -16'sd32768, 1'b0, '0},
		'{-16'sd32768, -16'sd32768, 1'b0, '0},
		'{16'sd32767, 16'sd32767, 1'b0, '0},
		'{16'sd32767, -16'sd32768, 1'b0, '0},
		'{-16'sd32768, 16'sd32767, 1'b0, '0},
		'{16'sd1, 16'sd0, 1'b0, '0},
		'{-16'sd1, 16'sd0, 1'b0, '0},
		'{16'sd0, -16'sd1, 1'b0, '0},
		'{16'sd12345, -16'sd5432, 1'b0, '0},
		'{-16'sd21846, 16'sd21845, 1'b0, '0}
	};

	// stimulus
	initial begin
		pll_out_t nil;
		logic signed [15:0] si, sq;
		int amp;
		nil = '0;
		fill_quarter_sine();
		predictor_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[r])
			send_request(directed[r].i_val, directed[r].q_val, directed[r].has_gold,
				directed[r].gold, 1'b1);
		drain();

		// quarter and three-quarter turn phases, quarter-turn steps
		write_reg(ctp_pkg::REG_SMOOTHING, 16'd0);
		write_reg(ctp_pkg::REG_LOW, 16'sd16384);
		write_reg(ctp_pkg::REG_HIGH, -16'sd1);
		write_reg(ctp_pkg::REG_CENTER, 16'sd16384);
		predictor_reset_step: begin
			send_request(16'sd100, 16'sd0, 1'b0, nil, 1'b0);
			for (int k = 0; k < 6; k++) send_request(16'sd0, 16'sd0, 1'b0, nil, 1'b1);
		end
		drain();

		for (int phase_no = 0; phase_no < 9; phase_no++) begin
			case (phase_no)
				0: begin
					write_reg(ctp_pkg::REG_SMOOTHING, ctp_pkg::BETA_RESET);
					write_reg(ctp_pkg::REG_CENTER, ctp_pkg::CENTER_RESET);
					write_reg(ctp_pkg::REG_LOW, ctp_pkg::LOW_RESET);
					write_reg(ctp_pkg::REG_HIGH, ctp_pkg::HIGH_RESET);
				end
				1: begin
					write_reg(ctp_pkg::REG_SMOOTHING, 16'hFFFF);
					write_reg(ctp_pkg::REG_LOW, -16'sd32768);
					write_reg(ctp_pkg::REG_HIGH, 16'sd32767);
				end
				2: begin
					write_reg(ctp_pkg::REG_SMOOTHING, 16'd0);
					write_reg(ctp_pkg::REG_CENTER, -16'sd32768);
				end
				3: begin
					write_reg(ctp_pkg::REG_CENTER, 16'sd32767);
					write_reg(ctp_pkg::REG_LOW, 16'sd32767);
					write_reg(ctp_pkg::REG_HIGH, -16'sd32768);
				end
				default: begin
					write_reg(ctp_pkg::REG_SMOOTHING, 16'($urandom));
					write_reg(ctp_pkg::REG_CENTER, 16'($urandom));
					write_reg(ctp_pkg::REG_LOW, 16'($urandom_range(0, 32767)) - 16'd16384);
					write_reg(ctp_pkg::REG_HIGH, low_q + 16'($urandom_range(0, 20000)));
				end
			endcase
			for (int n = 0; n < 150; n++) begin
				if (phase_no == 4 && n == 20) begin
					fork
						begin
							hold_off = 1'b1;
							repeat (400) @(posedge clk);
							hold_off = 1'b0;
						end
					join_none
				end
				if (phase_no == 5 && n == 75) begin
					s_tvalid <= 1'b0;
					@(posedge clk);
					while (expected_q.size() != 0) @(posedge clk);
				end
				amp = $urandom_range(0, 3);
				si = 16'($urandom);
				sq = 16'($urandom);
				if (amp == 0) begin
					si = si >>> 12; sq = sq >>> 12;
				end else if (amp == 1) begin
					si = si >>> 6; sq = sq >>> 6;
				end
				send_request(si, sq, 1'b0, nil, (n % 40) < 30);
			end
			drain();
		end

		if (fail_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ===== files.f =====
src/ctp_pkg.sv
src/ctp_datapath.sv
src/ctp_control.sv
src/carrier_tracking_pll.sv
bench/tb.sv
